// File: sv/cmyk_total_ink_limiter_core_defines.svh
// Assertion macros shared by the ink limiter RTL files.
`ifndef CMYK_TOTAL_INK_LIMITER_CORE_DEFINES_SVH
`define CMYK_TOTAL_INK_LIMITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cti_pkg.sv
// Types, constants and helper functions shared by the ink limiter modules.
`timescale 1ns / 1ps
package cti_pkg;

    localparam int unsigned COUNT_WIDTH = 32;
    localparam int unsigned OUT_COUNT_W = 32;
    localparam int unsigned PIX_W       = 8;
    localparam int unsigned CFG_W       = 9;
    localparam int unsigned SUM_W       = 10;
    localparam int unsigned LIMIT_W     = 17;
    localparam int unsigned CMY_W       = 10;

    localparam int unsigned PCT_SCALE   = 100;
    localparam int unsigned LIMIT_SLACK = 2;
    localparam int unsigned ROUND_HALF  = 50;

    // x / 100 as (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2^17.
    localparam int unsigned RECIP_100   = 167773;
    localparam int unsigned RECIP_W     = 18;
    localparam int unsigned RECIP_SHIFT = 24;

    localparam logic [CFG_W-1:0] INK_RESET = CFG_W'(300);

    // Divider: 8 quotient bits, dividend 2*v*num+den, divisor 2*den.
    localparam int unsigned QBITS  = 8;
    localparam int unsigned QCNT_W = $clog2(QBITS);
    localparam int unsigned REM_W  = 26;
    localparam int unsigned DVS_W  = LIMIT_W + QBITS;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W_Q    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [PIX_W-1:0]       PIX_MAX   = {PIX_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_BLACK,
        MODE_SCALE,
        MODE_KEEP
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } t_back_state;

    typedef struct packed {
        logic [PIX_W-1:0] cyan_in;
        logic [PIX_W-1:0] magenta_in;
        logic [PIX_W-1:0] yellow_in;
        logic [PIX_W-1:0] black_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0]       cyan_out;
        logic [PIX_W-1:0]       magenta_out;
        logic [PIX_W-1:0]       yellow_out;
        logic [PIX_W-1:0]       black_out;
        logic                   was_modified;
        logic [OUT_COUNT_W-1:0] modified_count;
        logic [SUM_W-1:0]       peak_sum_before;
        logic [SUM_W-1:0]       peak_sum_after;
    } t_pix_out;

    // A classified pixel as it waits in the queue.
    typedef struct packed {
        t_mode              mode;
        logic [PIX_W-1:0]   c;
        logic [PIX_W-1:0]   m;
        logic [PIX_W-1:0]   y;
        logic [PIX_W-1:0]   k;
        logic [SUM_W-1:0]   sum;
        logic [LIMIT_W-1:0] num;
        logic [LIMIT_W-1:0] den;
    } t_work;

    typedef struct packed {
        logic  valid;
        t_work work;
    } t_work_chan;

    // 255 * v, done as a shift and a subtract.
    function automatic logic [LIMIT_W-1:0] limit_of(input logic [CFG_W-1:0] v);
        logic [LIMIT_W-1:0] hi;
        logic [LIMIT_W-1:0] lo;
        hi = {v, 8'b0};
        lo = LIMIT_W'(v);
        return hi - lo;
    endfunction

    // round(limit / 100), saturated to one byte.
    function automatic logic [PIX_W-1:0] kblack_of(input logic [LIMIT_W-1:0] limit);
        logic [LIMIT_W:0]                 rounded;
        logic [LIMIT_W+RECIP_W:0]         prod;
        logic [LIMIT_W+RECIP_W-RECIP_SHIFT:0] quo;
        rounded = (LIMIT_W+1)'(limit) + (LIMIT_W+1)'(ROUND_HALF);
        prod    = (LIMIT_W+RECIP_W+1)'(rounded) * (LIMIT_W+RECIP_W+1)'(RECIP_100);
        quo     = prod[LIMIT_W+RECIP_W:RECIP_SHIFT];
        if (quo > (LIMIT_W+RECIP_W-RECIP_SHIFT+1)'(PIX_MAX)) begin
            return PIX_MAX;
        end
        return quo[PIX_W-1:0];
    endfunction

endpackage

// File: sv/cti_front.sv
// Front end: accepts pixels and classifies them against the ink limit.
`timescale 1ns / 1ps
module cti_front (
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  cti_pkg::t_pix_in          i_pix,
    input  logic [cti_pkg::LIMIT_W-1:0] i_limit,
    input  logic                      i_q_full,
    output cti_pkg::t_work_chan       o_push
);
    import cti_pkg::*;

    logic [SUM_W-1:0]   sum;
    logic [CMY_W-1:0]   cmy;
    logic [LIMIT_W:0]   sum100;
    logic [LIMIT_W:0]   thresh;
    logic [LIMIT_W-1:0] k100;
    logic [LIMIT_W-1:0] num;
    logic [LIMIT_W-1:0] den;
    t_mode              mode;

    always_comb begin
        cmy    = CMY_W'(i_pix.cyan_in) + CMY_W'(i_pix.magenta_in) + CMY_W'(i_pix.yellow_in);
        sum    = SUM_W'(cmy) + SUM_W'(i_pix.black_in);
        sum100 = (LIMIT_W+1)'(sum) * (LIMIT_W+1)'(PCT_SCALE);
        thresh = (LIMIT_W+1)'(i_limit) + (LIMIT_W+1)'(LIMIT_SLACK);
        k100   = LIMIT_W'(i_pix.black_in) * LIMIT_W'(PCT_SCALE);
        num    = i_limit - k100;
        den    = LIMIT_W'(cmy) * LIMIT_W'(PCT_SCALE);
        priority if (sum100 <= thresh) begin
            mode = MODE_PASS;
        end else if (k100 >= i_limit) begin
            mode = MODE_BLACK;
        end else if (cmy == '0 || num >= den) begin
            mode = MODE_KEEP;
        end else begin
            mode = MODE_SCALE;
        end
    end

    assign o_in_ready = !i_q_full;

    always_comb begin
        o_push.valid     = i_in_valid && !i_q_full;
        o_push.work.mode = mode;
        o_push.work.c    = i_pix.cyan_in;
        o_push.work.m    = i_pix.magenta_in;
        o_push.work.y    = i_pix.yellow_in;
        o_push.work.k    = i_pix.black_in;
        o_push.work.sum  = sum;
        o_push.work.num  = num;
        o_push.work.den  = den;
    end

endmodule

// File: sv/cti_queue.sv
// Short queue of classified pixels between the front and back ends.
`timescale 1ns / 1ps
`include "cmyk_total_ink_limiter_core_defines.svh"
module cti_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cti_pkg::t_work_chan i_push,
    output logic                o_full,
    output cti_pkg::t_work_chan o_head,
    input  logic                i_pop
);
    import cti_pkg::*;

    t_work               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W_Q-1:0] r_count;
    logic [QCNT_W_Q-1:0] n_count;
    logic                push;
    logic                pop;

    assign push = i_push.valid;
    assign pop  = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + QCNT_W_Q'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W_Q'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.work;
        end
    end

    assign o_full       = (r_count == QCNT_W_Q'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.work  = r_mem[r_rd_ptr];

    `CTI_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, push, r_count != QCNT_W_Q'(QUEUE_DEPTH), "queue written while full")
    `CTI_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + QCNT_W_Q'(1), "queue count did not grow on push")
    `CTI_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "queue popped while empty")

endmodule

// File: sv/cti_back.sv
// Back end: scales pixels with a bit-serial divider, keeps statistics, drives the output.
`timescale 1ns / 1ps
`include "cmyk_total_ink_limiter_core_defines.svh"
module cti_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cti_pkg::t_work_chan         i_head,
    output logic                        o_pop,
    input  logic [cti_pkg::LIMIT_W-1:0] i_limit,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output cti_pkg::t_pix_out           o_out
);
    import cti_pkg::*;

    typedef struct packed {
        logic pop;
        logic mul;
        logic div;
        logic emit;
    } t_back_ctl;

    t_back_state        r_state;
    t_back_state        n_state;
    t_back_ctl          ctl;
    logic               can_emit;

    logic [PIX_W-1:0]   r_kblack;
    t_mode              r_mode;
    logic [PIX_W-1:0]   r_cmy [3];
    logic [PIX_W-1:0]   r_k;
    logic [SUM_W-1:0]   r_sum;
    logic [LIMIT_W-1:0] r_num;
    logic [LIMIT_W-1:0] r_den;
    logic [REM_W-1:0]   r_rem [3];
    logic [DVS_W-1:0]   r_dvs;
    logic [QCNT_W-1:0]  r_bit;

    logic [REM_W-1:0]   prod [3];
    logic [REM_W:0]     trial [3];
    logic [2:0]         ge;

    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [SUM_W-1:0]       r_peak_before;
    logic [SUM_W-1:0]       n_peak_before;
    logic [SUM_W-1:0]       r_peak_after;
    logic [SUM_W-1:0]       n_peak_after;
    logic [SUM_W-1:0]       out_sum;
    logic [63:0]            count_wide;
    logic                   modified;

    logic     r_out_valid;
    t_pix_out r_out;
    t_pix_out n_out;

    assign can_emit = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_state = (i_head.work.mode == MODE_SCALE) ? ST_MUL : ST_EMIT;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_bit == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (can_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        ctl = '0;
        unique case (r_state)
            ST_IDLE: ctl.pop  = i_head.valid;
            ST_MUL:  ctl.mul  = 1'b1;
            ST_DIV:  ctl.div  = 1'b1;
            ST_EMIT: ctl.emit = can_emit;
            default: ctl      = '0;
        endcase
    end

    assign o_pop = ctl.pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Black-only level follows the limit register.
    always_ff @(posedge i_clk) begin
        r_kblack <= kblack_of(i_limit);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i]  = REM_W'({r_cmy[i], 1'b0}) * REM_W'(r_num);
            trial[i] = (REM_W+1)'(r_rem[i]) - (REM_W+1)'(r_dvs);
            ge[i]    = !trial[i][REM_W];
        end
    end

    // Working registers and the three divider lanes.
    always_ff @(posedge i_clk) begin
        if (ctl.pop) begin
            r_mode <= i_head.work.mode;
            r_sum  <= i_head.work.sum;
            r_num  <= i_head.work.num;
            r_den  <= i_head.work.den;
            if (i_head.work.mode == MODE_BLACK) begin
                r_cmy[0] <= '0;
                r_cmy[1] <= '0;
                r_cmy[2] <= '0;
                r_k      <= r_kblack;
            end else begin
                r_cmy[0] <= i_head.work.c;
                r_cmy[1] <= i_head.work.m;
                r_cmy[2] <= i_head.work.y;
                r_k      <= i_head.work.k;
            end
        end else if (ctl.mul) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= prod[i] + REM_W'(r_den);
            end
            r_dvs <= {r_den, {QBITS{1'b0}}};
            r_bit <= QCNT_W'(QBITS - 1);
        end else if (ctl.div) begin
            for (int i = 0; i < 3; i++) begin
                if (ge[i]) begin
                    r_rem[i] <= trial[i][REM_W-1:0];
                end
                r_cmy[i] <= {r_cmy[i][PIX_W-2:0], ge[i]};
            end
            r_dvs <= r_dvs >> 1;
            r_bit <= r_bit - QCNT_W'(1);
        end
    end

    // Statistics and the result as it leaves.
    always_comb begin
        modified = (r_mode != MODE_PASS);
        out_sum  = SUM_W'(r_cmy[0]) + SUM_W'(r_cmy[1]) + SUM_W'(r_cmy[2]) + SUM_W'(r_k);
        n_count  = (modified && r_count != COUNT_MAX) ? r_count + COUNT_WIDTH'(1) : r_count;
        n_peak_before = (r_sum > r_peak_before) ? r_sum : r_peak_before;
        n_peak_after  = (out_sum > r_peak_after) ? out_sum : r_peak_after;
        count_wide    = 64'(n_count);
        n_out.cyan_out        = r_cmy[0];
        n_out.magenta_out     = r_cmy[1];
        n_out.yellow_out      = r_cmy[2];
        n_out.black_out       = r_k;
        n_out.was_modified    = modified;
        n_out.modified_count  = count_wide[OUT_COUNT_W-1:0];
        n_out.peak_sum_before = n_peak_before;
        n_out.peak_sum_after  = n_peak_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_peak_before <= '0;
            r_peak_after  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (ctl.emit) begin
                r_count       <= n_count;
                r_peak_before <= n_peak_before;
                r_peak_after  <= n_peak_after;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `CTI_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, r_state == ST_DIV && r_bit == '0, r_state == ST_EMIT, "divider did not finish after its last bit")
    `CTI_ASSERT_NOW(a_peak_order, i_clk, i_rst_n, 1'b1, r_peak_after <= r_peak_before, "output peak above input peak")
    `CTI_ASSERT_NOW(a_count_seen, i_clk, i_rst_n, r_out_valid && r_out.was_modified, r_count != '0, "modified pixel with zero count")

endmodule

// File: sv/cmyk_total_ink_limiter_core.sv
// Top level of the CMYK total ink limiter: limit register, front end, queue and back end.
//
//   Channel   Direction  Handshake                     Payload
//   config    in         i_cfg_valid / o_cfg_ready     i_cfg_data, ink limit in percent
//   pixel in  in         i_in_valid  / o_in_ready      i_in_data, t_pix_in
//   pixel out out        o_out_valid / i_out_ready     o_out_data, t_pix_out
//
// A pixel that passes, goes to black only, or keeps its values goes through the idle
// and emit steps of the back end; a scaled pixel also takes a multiply step and the
// one-bit-per-cycle divider that works its C, M and Y side by side.
// The front end classifies in the cycle of the transfer and feeds a two-entry queue, so
// the input keeps taking pixels while the back end divides or the output is stalled,
// until both queue entries are in use.
// The output register holds one finished result; the back end moves on to the next
// pixel right away and only waits in its emit step while the held result has not been
// taken. Reset is synchronous and active low, and clears the
// limit to 300 percent, the modified count and both peak sums.
`timescale 1ns / 1ps
module cmyk_total_ink_limiter_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [cti_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  cti_pkg::t_pix_in          i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output cti_pkg::t_pix_out         o_out_data
);
    import cti_pkg::*;

    // The limit is kept as 255 times the percentage, which is the form every compare uses.
    logic [LIMIT_W-1:0] r_limit;
    t_work_chan         push;
    t_work_chan         head;
    logic               q_full;
    logic               pop;

    // Configuration is always accepted; it must only be written while no pixel is in flight.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= limit_of(INK_RESET);
        end else if (i_cfg_valid) begin
            r_limit <= limit_of(i_cfg_data);
        end
    end

    // Classification: pass, black only, keep, or scale.
    cti_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pix      (i_in_data),
        .i_limit    (r_limit),
        .i_q_full   (q_full),
        .o_push     (push)
    );

    // Decouples the input transfer from the divider.
    cti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Scaling, statistics and the output register.
    cti_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_limit     (r_limit),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

// File: bench/cmyk_total_ink_limiter_core_tb.sv
// Self-checking testbench for the CMYK total ink limiter core.
`timescale 1ns / 1ps
module cmyk_total_ink_limiter_core_tb;
    import cti_pkg::*;

    // Far above the slowest correct run: about 1200 pixels, all through the divider at worst,
    // plus long sender gaps and receiver stalls.
    localparam int unsigned CYCLE_LIMIT = 600000;
    // Quiet cycles after the last expected result, a little over the divide latency.
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned REPORT_MAX = 10;
    localparam int unsigned PIXELS_PER_PHASE = 90;

    // Golden model of the limiter. It keeps its own copy of the limit register,
    // the modified-pixel counter and both peak sums, and it queues the result
    // that each pixel transfer must produce.
    class ink_scoreboard;
        localparam int unsigned INK_FULL = 255;
        localparam int unsigned PCT = 100;

        logic [CFG_W-1:0]       limit_pct;
        logic [COUNT_WIDTH-1:0] modified_total;
        logic [SUM_W-1:0]       peak_in;
        logic [SUM_W-1:0]       peak_out;
        t_pix_out               limited_q[$];
        int unsigned            mismatches;

        function new();
            limit_pct      = INK_RESET;
            modified_total = '0;
            peak_in        = '0;
            peak_out       = '0;
            mismatches     = 0;
        endfunction

        function void set_limit(logic [CFG_W-1:0] pct);
            limit_pct = pct;
        endfunction

        function int unsigned pending();
            return limited_q.size();
        endfunction

        // Round half up of v*num/den.
        function int unsigned round_ratio(int unsigned v, int unsigned num, int unsigned den);
            longint unsigned top;
            top = 2 * longint'(v) * longint'(num) + longint'(den);
            return int'(top / (2 * longint'(den)));
        endfunction

        // Works out the limited pixel and the running statistics for one transfer.
        function void note_pixel(t_pix_in px);
            int unsigned c, m, y, k, lim, total, cmy, num, den, out_total;
            bit          over;
            t_pix_out    r;
            c     = px.cyan_in;
            m     = px.magenta_in;
            y     = px.yellow_in;
            k     = px.black_in;
            lim   = INK_FULL * limit_pct;
            total = c + m + y + k;
            if (total > peak_in) begin
                peak_in = SUM_W'(total);
            end
            over = (PCT * total > lim + 2);
            if (over) begin
                if (PCT * k >= lim) begin
                    // Black alone reaches the limit: drop the colors, black goes to the limit.
                    c = 0;
                    m = 0;
                    y = 0;
                    k = (lim + PCT / 2) / PCT;
                    if (k > INK_FULL) begin
                        k = INK_FULL;
                    end
                end else begin
                    cmy = c + m + y;
                    num = lim - PCT * k;
                    den = PCT * cmy;
                    if (cmy > 0 && num < den) begin
                        c = round_ratio(c, num, den);
                        m = round_ratio(m, num, den);
                        y = round_ratio(y, num, den);
                    end
                end
                if (modified_total != COUNT_MAX) begin
                    modified_total = modified_total + 1'b1;
                end
            end
            out_total = c + m + y + k;
            if (out_total > peak_out) begin
                peak_out = SUM_W'(out_total);
            end
            r.cyan_out        = PIX_W'(c);
            r.magenta_out     = PIX_W'(m);
            r.yellow_out      = PIX_W'(y);
            r.black_out       = PIX_W'(k);
            r.was_modified    = over;
            r.modified_count  = OUT_COUNT_W'(modified_total);
            r.peak_sum_before = peak_in;
            r.peak_sum_after  = peak_out;
            limited_q.push_back(r);
        endfunction

        function void field_ok(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("mismatch on %s: expected %0d, got %0d", field, want, got);
                end
            end
        endfunction

        function void check_result(t_pix_out got);
            t_pix_out want;
            if (limited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result: %p", got);
                end
                return;
            end
            want = limited_q.pop_front();
            field_ok("cyan_out", want.cyan_out, got.cyan_out);
            field_ok("magenta_out", want.magenta_out, got.magenta_out);
            field_ok("yellow_out", want.yellow_out, got.yellow_out);
            field_ok("black_out", want.black_out, got.black_out);
            field_ok("was_modified", want.was_modified, got.was_modified);
            field_ok("modified_count", want.modified_count, got.modified_count);
            field_ok("peak_sum_before", want.peak_sum_before, got.peak_sum_before);
            field_ok("peak_sum_after", want.peak_sum_after, got.peak_sum_after);
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    t_pix_in          i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_pix_out         o_out_data;

    ink_scoreboard sb = new();

    // Sender burst state: pixels left in the current burst, and whether this
    // phase runs back to back with no gaps at all.
    int unsigned tx_burst = 0;
    bit          tx_steady = 1'b0;

    cmyk_total_ink_limiter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a run that reaches the cycle limit has hung somewhere.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: checks every result transfer and stalls on a pattern of its own.
    // The pattern switches now and then between always ready, mostly ready,
    // mostly stalled, and a fixed duty cycle.
    initial begin
        int unsigned rx_mode;
        int unsigned rx_left;
        int unsigned rx_tick;
        rx_mode = 0;
        rx_left = 0;
        rx_tick = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            // Values read here are the ones the edge itself sampled.
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_result(o_out_data);
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(50, 400);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ((rx_tick % 7) >= 3);
            endcase
        end
    end

    // Offers one pixel and returns at the edge of its transfer. The valid stays
    // high on return, so the caller must, in the same time step, either offer the
    // next pixel or drop the valid through stop_pixels.
    task automatic send_pixel(input t_pix_in px);
        int unsigned gap;
        if (!tx_steady && tx_burst == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            tx_burst = $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sb.note_pixel(px);
        if (tx_burst > 0) begin
            tx_burst--;
        end
    endtask

    task automatic stop_pixels();
        i_in_valid <= 1'b0;
    endtask

    task automatic send_cmyk(input int unsigned c, input int unsigned m,
                             input int unsigned y, input int unsigned k);
        t_pix_in px;
        px.cyan_in    = PIX_W'(c);
        px.magenta_in = PIX_W'(m);
        px.yellow_in  = PIX_W'(y);
        px.black_in   = PIX_W'(k);
        send_pixel(px);
    endtask

    // Lets the block drain so that the limit register is only written while idle.
    task automatic settle();
        stop_pixels();
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input int unsigned pct);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CFG_W'(pct);
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        sb.set_limit(CFG_W'(pct));
    endtask

    function automatic int unsigned corner_byte();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 127;
            3: return 128;
            4: return 254;
            default: return 255;
        endcase
    endfunction

    // Random pixel for the current limit. Two in five pixels sit close to the limit or
    // carry heavy black, since that is where the three outcomes meet.
    function automatic t_pix_in random_pixel(input int unsigned pct);
        t_pix_in     px;
        int unsigned v[4];
        int          target;
        int unsigned rem, lo, hi, rot, pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            foreach (v[i]) v[i] = $urandom_range(0, 255);
        end else if (pick < 55) begin
            // Total ink right around the limit, split at random over the channels.
            target = int'((255 * pct) / 100);
            if (target > 1020) begin
                target = $urandom_range(900, 1020);
            end
            target = target + int'($urandom_range(0, 6)) - 3;
            if (target < 0) target = 0;
            if (target > 1020) target = 1020;
            rem = target;
            for (int i = 0; i < 4; i++) begin
                lo = (rem > 255 * (3 - i)) ? rem - 255 * (3 - i) : 0;
                hi = (rem < 255) ? rem : 255;
                v[i] = $urandom_range(hi, lo);
                rem = rem - v[i];
            end
            rot = $urandom_range(0, 3);
            v = '{v[rot % 4], v[(rot + 1) % 4], v[(rot + 2) % 4], v[(rot + 3) % 4]};
        end else if (pick < 70) begin
            // Black near the level where it alone reaches the limit.
            target = int'((255 * pct) / 100) + int'($urandom_range(0, 4)) - 2;
            if (target < 0) target = 0;
            if (target > 255) target = 255;
            v[0] = $urandom_range(0, 255);
            v[1] = $urandom_range(0, 255);
            v[2] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 255);
            v[3] = target;
        end else if (pick < 85) begin
            foreach (v[i]) v[i] = corner_byte();
        end else if (pick < 93) begin
            foreach (v[i]) v[i] = $urandom_range(0, 20);
        end else begin
            foreach (v[i]) v[i] = $urandom_range(230, 255);
        end
        px.cyan_in    = PIX_W'(v[0]);
        px.magenta_in = PIX_W'(v[1]);
        px.yellow_in  = PIX_W'(v[2]);
        px.black_in   = PIX_W'(v[3]);
        return px;
    endfunction

    task automatic random_pixels(input int unsigned count);
        tx_steady = ($urandom_range(0, 3) == 0);
        tx_burst  = 0;
        repeat (count) send_pixel(random_pixel(sb.limit_pct));
    endtask

    // Stimulus: one phase per limit setting, each one started from an idle block.
    initial begin
        int unsigned limits[$];
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset limit of 300 percent: empty, full, exactly at the limit, one over.
        send_cmyk(0, 0, 0, 0);
        send_cmyk(255, 255, 255, 255);
        send_cmyk(255, 255, 255, 0);
        send_cmyk(255, 255, 255, 1);
        send_cmyk(0, 0, 0, 255);
        send_cmyk(255, 0, 255, 255);
        random_pixels(PIXELS_PER_PHASE);

        // A zero limit turns any pixel with some ink into an empty one.
        settle();
        write_limit(0);
        send_cmyk(0, 0, 0, 0);
        send_cmyk(1, 0, 0, 0);
        send_cmyk(0, 0, 0, 1);
        send_cmyk(255, 255, 255, 255);
        random_pixels(PIXELS_PER_PHASE);

        // At 400 percent a full pixel sits exactly on the limit.
        settle();
        write_limit(400);
        send_cmyk(255, 255, 255, 255);
        random_pixels(PIXELS_PER_PHASE);

        // Largest register value: nothing can exceed it.
        settle();
        write_limit(511);
        send_cmyk(255, 255, 255, 255);
        random_pixels(PIXELS_PER_PHASE);

        // At 100 percent full black alone reaches the limit.
        settle();
        write_limit(100);
        send_cmyk(0, 0, 0, 255);
        send_cmyk(1, 0, 0, 255);
        send_cmyk(0, 0, 1, 255);
        send_cmyk(128, 128, 0, 0);
        send_cmyk(85, 85, 85, 0);
        random_pixels(PIXELS_PER_PHASE);

        // Tiny limit: black rounds to three, small colors scale with rounding.
        settle();
        write_limit(1);
        send_cmyk(0, 0, 0, 3);
        send_cmyk(0, 0, 0, 2);
        send_cmyk(2, 0, 0, 1);
        random_pixels(PIXELS_PER_PHASE);

        limits = '{250, 320, 200, 256};
        repeat (3) limits.push_back($urandom_range(0, 511));
        foreach (limits[i]) begin
            settle();
            write_limit(limits[i]);
            random_pixels(PIXELS_PER_PHASE);
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
